### rtl/tlbpt_pkg.sv
// Shared types and constants for the TLB and page-table translation unit.
package tlbpt_pkg;

  localparam int ADDR_W = 16;
  localparam int PAGE_W = 8;
  localparam int OFF_W  = 8;

  // Reset value of the TLB victim LFSR
  localparam logic [15:0] LFSR_SEED = 16'hACE1;

  typedef logic [PAGE_W-1:0] page_t;

  // Update requests from the sequencer to the TLB
  typedef struct packed {
    logic  inv_en;
    page_t inv_page;
    logic  fill_en;
    page_t fill_page;
    page_t fill_frame;
  } tlbpt_tlb_ctl_t;

  // Read addresses and write requests from the sequencer to the tables
  typedef struct packed {
    page_t pf_raddr;
    page_t ow_raddr;
    logic  pf_we;
    page_t pf_waddr;
    page_t pf_wdata;
    logic  pv_set;
    page_t pv_set_page;
    logic  pv_clr;
    page_t pv_clr_page;
    logic  ow_we;
    page_t ow_waddr;
    page_t ow_wdata;
  } tlbpt_tab_ctl_t;

endpackage

### rtl/tlbpt_vmod.sv
// Remainder of the victim LFSR by the number of TLB entries, by reciprocal multiplication.
module tlbpt_vmod import tlbpt_pkg::*; #(
  parameter int TLB_ENTRIES = 16
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         start,
  input  logic [15:0]                                  value,
  output logic [(TLB_ENTRIES > 1 ? $clog2(TLB_ENTRIES) : 1)-1:0] rem,
  output logic                                         done
);

  localparam int IW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int SH = 16 + $clog2(TLB_ENTRIES);
  // Rounded-up reciprocal, exact for every 16-bit value
  localparam logic [39:0] RECIP =
    ((40'd1 << SH) + 40'(TLB_ENTRIES) - 40'd1) / 40'(TLB_ENTRIES);
  localparam logic [16:0] RECIP_M = RECIP[16:0];
  localparam logic [15:0] DIVISOR = 16'(TLB_ENTRIES);

  logic [15:0]   val_r, val_nxt;
  logic [15:0]   q_r, q_nxt;
  logic [IW-1:0] rem_r, rem_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic [32:0]   prod;
  logic [15:0]   diff;

  assign prod = 33'(val_r) * 33'(RECIP_M);
  assign diff = val_r - q_r * DIVISOR;

  // Quotient step, then remainder step from the registered quotient
  always_comb begin
    val_nxt = val_r;
    q_nxt   = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    if (start) begin
      val_nxt = value;
      cnt_nxt = 2'd2;
    end else if (cnt_r == 2'd2) begin
      q_nxt   = 16'(prod >> SH);
      cnt_nxt = 2'd1;
    end else if (cnt_r == 2'd1) begin
      rem_nxt = diff[IW-1:0];
      cnt_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= LFSR_SEED;
      q_r   <= '0;
      rem_r <= '0;
      cnt_r <= 2'd2;
    end else begin
      val_r <= val_nxt;
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign rem  = rem_r;
  assign done = (cnt_r == 2'd0);

endmodule

### rtl/tlbpt_tlb.sv
// Fully associative TLB with free-entry refill and LFSR victim choice.
module tlbpt_tlb import tlbpt_pkg::*; #(
  parameter int TLB_ENTRIES = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  page_t          look_page,
  input  tlbpt_tlb_ctl_t ctl,
  output logic           hit,
  output page_t          hit_frame,
  output logic           fill_ready
);

  localparam int IW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

  logic [TLB_ENTRIES-1:0] valid_r;
  page_t                  page_r  [TLB_ENTRIES];
  page_t                  frame_r [TLB_ENTRIES];
  logic [15:0]            lfsr_r, lfsr_nxt;

  logic          inv_hit, free_any, mod_done;
  logic [IW-1:0] hit_idx, inv_idx, free_idx, vic_idx, slot;

  // Lowest-index match, lowest-index invalidation match, lowest free entry
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    inv_hit  = 1'b0;
    inv_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && page_r[i] == look_page) begin
        hit     = 1'b1;
        hit_idx = IW'(i);
      end
      if (valid_r[i] && page_r[i] == ctl.inv_page) begin
        inv_hit = 1'b1;
        inv_idx = IW'(i);
      end
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  assign hit_frame  = frame_r[hit_idx];
  assign slot       = free_any ? free_idx : vic_idx;
  assign fill_ready = free_any || mod_done;
  assign lfsr_nxt   = {lfsr_r[0] ^ lfsr_r[2] ^ lfsr_r[3] ^ lfsr_r[5], lfsr_r[15:1]};

  // Invalidate an evicted page, then refill on a miss and step the LFSR on a random replacement
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      lfsr_r  <= LFSR_SEED;
    end else begin
      if (ctl.inv_en && inv_hit) begin
        valid_r[inv_idx] <= 1'b0;
      end
      if (ctl.fill_en) begin
        valid_r[slot] <= 1'b1;
        if (!free_any) begin
          lfsr_r <= lfsr_nxt;
        end
      end
    end
  end

  // Entry payload
  always_ff @(posedge clk) begin
    if (ctl.fill_en) begin
      page_r[slot]  <= ctl.fill_page;
      frame_r[slot] <= ctl.fill_frame;
    end
  end

  tlbpt_vmod #(.TLB_ENTRIES(TLB_ENTRIES)) u_vmod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.fill_en && !free_any),
    .value (lfsr_nxt),
    .rem   (vic_idx),
    .done  (mod_done)
  );

endmodule

### rtl/tlbpt_tables.sv
// Page table and frame-owner memories with their valid bits.
module tlbpt_tables import tlbpt_pkg::*; #(
  parameter int FRAME_COUNT = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  tlbpt_tab_ctl_t ctl,
  output page_t          pf_rdata,
  output page_t          ow_rdata,
  output logic [255:0]   page_valid
);

  localparam int FW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;

  page_t                  pf_mem [256];
  page_t                  ow_mem [FRAME_COUNT];
  logic [255:0]           pv_r;
  logic [FRAME_COUNT-1:0] ow_vld_r;
  page_t                  pf_q_r, ow_q_r;
  logic                   ow_hit_r;

  // Page-frame memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (ctl.pf_we) begin
      pf_mem[ctl.pf_waddr] <= ctl.pf_wdata;
    end
    pf_q_r <= pf_mem[ctl.pf_raddr];
  end

  // Frame-owner memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (ctl.ow_we) begin
      ow_mem[ctl.ow_waddr[FW-1:0]] <= ctl.ow_wdata;
    end
    ow_q_r <= ow_mem[ctl.ow_raddr[FW-1:0]];
  end

  // Valid bits: owners never written read as page zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r     <= '0;
      ow_vld_r <= '0;
      ow_hit_r <= 1'b0;
    end else begin
      if (ctl.pv_clr) begin
        pv_r[ctl.pv_clr_page] <= 1'b0;
      end
      if (ctl.pv_set) begin
        pv_r[ctl.pv_set_page] <= 1'b1;
      end
      if (ctl.ow_we) begin
        ow_vld_r[ctl.ow_waddr[FW-1:0]] <= 1'b1;
      end
      ow_hit_r <= ow_vld_r[ctl.ow_raddr[FW-1:0]];
    end
  end

  assign pf_rdata   = pf_q_r;
  assign ow_rdata   = ow_hit_r ? ow_q_r : '0;
  assign page_valid = pv_r;

endmodule

### rtl/tlb_page_table_fifo_mmu.sv
// Top level: translation sequencer, result register and stream ports.
// Translates one 16-bit logical address at a time. A TLB hit presents its
// result from the lookup state. A miss to a resident page reads the page
// table; a page fault reads the owner of the ring frame, then that
// owner's page-table entry, then writes back, as the page-table and
// frame-owner memories have registered reads. Each miss then refills the
// TLB. A full output register stalls the lookup and the refill. When the
// TLB is full, the victim index is reduced from the LFSR after each random
// replacement, ahead of the next refill, so it adds no wait. A new input is
// taken once the previous result is in the output register, even if not
// yet taken downstream. No clearing pass is needed after reset.
module tlb_page_table_fifo_mmu import tlbpt_pkg::*; #(
  parameter int TLB_ENTRIES = 16,
  parameter int FRAME_COUNT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // logical_address
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // physical_address[15:0], evicted_page[23:16]
  output logic [2:0]  out_tuser   // tlb_hit[0], page_fault[1], evicted[2]
);

  localparam int FW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam logic [FW-1:0] PTR_LAST = FW'(FRAME_COUNT - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EV   = 3'd3;
  localparam logic [2:0] S_FILL = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [15:0]   addr_r;
  logic [FW-1:0] ptr_r, ptr_nxt;
  page_t         frame_r, frame_nxt, owner_r, owner_nxt, evp_r, evp_nxt;
  logic          fault_r, fault_nxt, ev_r, ev_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [23:0]   out_data_r, out_data_nxt;
  logic [2:0]    out_user_r, out_user_nxt;

  page_t          pg;
  logic           out_free;
  tlbpt_tlb_ctl_t tlb_ctl;
  tlbpt_tab_ctl_t tab_ctl;
  logic           tlb_hit, fill_ready;
  page_t          hit_frame, pf_rdata, ow_rdata;
  logic [255:0]   page_valid;

  assign pg        = addr_r[15:8];
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  // Sequence lookup, page-table walk, eviction and refill
  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    frame_nxt     = frame_r;
    owner_nxt     = owner_r;
    evp_nxt       = evp_r;
    fault_nxt     = fault_r;
    ev_nxt        = ev_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    tlb_ctl       = '0;
    tlb_ctl.inv_page   = owner_r;
    tlb_ctl.fill_page  = pg;
    tlb_ctl.fill_frame = frame_r;
    tab_ctl       = '0;
    tab_ctl.pf_raddr   = pg;
    tab_ctl.ow_raddr   = 8'(ptr_r);
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        fault_nxt = 1'b0;
        ev_nxt    = 1'b0;
        evp_nxt   = '0;
        if (tlb_hit) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = {8'd0, hit_frame, addr_r[7:0]};
            out_user_nxt  = 3'b001;
            state_nxt     = S_IDLE;
          end
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (page_valid[pg]) begin
          frame_nxt = pf_rdata;
          state_nxt = S_FILL;
        end else begin
          fault_nxt        = 1'b1;
          frame_nxt        = 8'(ptr_r);
          owner_nxt        = ow_rdata;
          tab_ctl.ow_we    = 1'b1;
          tab_ctl.ow_waddr = 8'(ptr_r);
          tab_ctl.ow_wdata = pg;
          tab_ctl.pf_raddr = ow_rdata;
          ptr_nxt          = (ptr_r == PTR_LAST) ? '0 : ptr_r + FW'(1);
          state_nxt        = S_EV;
        end
      end
      S_EV: begin
        if (page_valid[owner_r] && pf_rdata == frame_r) begin
          ev_nxt              = 1'b1;
          evp_nxt             = owner_r;
          tab_ctl.pv_clr      = 1'b1;
          tab_ctl.pv_clr_page = owner_r;
          tlb_ctl.inv_en      = 1'b1;
        end
        tab_ctl.pf_we       = 1'b1;
        tab_ctl.pf_waddr    = pg;
        tab_ctl.pf_wdata    = frame_r;
        tab_ctl.pv_set      = 1'b1;
        tab_ctl.pv_set_page = pg;
        state_nxt           = S_FILL;
      end
      S_FILL: begin
        if (fill_ready && out_free) begin
          tlb_ctl.fill_en = 1'b1;
          out_valid_nxt   = 1'b1;
          out_data_nxt    = {evp_r, frame_r, addr_r[7:0]};
          out_user_nxt    = {ev_r, fault_r, 1'b0};
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Item payload and result register
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      addr_r <= in_tdata;
    end
    frame_r    <= frame_nxt;
    owner_r    <= owner_nxt;
    evp_r      <= evp_nxt;
    fault_r    <= fault_nxt;
    ev_r       <= ev_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  tlbpt_tlb #(.TLB_ENTRIES(TLB_ENTRIES)) u_tlb (
    .clk        (clk),
    .rst_n      (rst_n),
    .look_page  (pg),
    .ctl        (tlb_ctl),
    .hit        (tlb_hit),
    .hit_frame  (hit_frame),
    .fill_ready (fill_ready)
  );

  tlbpt_tables #(.FRAME_COUNT(FRAME_COUNT)) u_tables (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (tab_ctl),
    .pf_rdata   (pf_rdata),
    .ow_rdata   (ow_rdata),
    .page_valid (page_valid)
  );

  // A TLB hit never reports a fault
  a_hit_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_user_r[0] && out_user_r[1]))
    else $error("hit reported together with fault");

  // Eviction happens only on a fault, and the page field is zero otherwise
  a_ev_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_user_r[2] |-> out_user_r[1])
    else $error("eviction without fault");

  a_evp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_user_r[2] |-> out_data_r[23:16] == 8'd0)
    else $error("evicted page set without eviction");

  // The frame pointer advances exactly on leaving the page-table read on a fault
  a_ptr_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD && !page_valid[pg] |=> state_r == S_EV && ptr_r != $past(ptr_r)
      || FRAME_COUNT == 1)
    else $error("frame pointer did not advance on fault");

endmodule

### sim/tlb_page_table_fifo_mmu_tb.sv
// Self-checking testbench for the TLB and page-table translation unit.
module tlb_page_table_fifo_mmu_tb;
  import tlbpt_pkg::*;

  localparam int TLB_N    = 16;
  localparam int FRAMES   = 256;
  localparam int WD_LIMIT = 20000;

  typedef struct packed {
    logic [15:0] phys;
    logic        hit;
    logic        fault;
    logic        evicted;
    logic [7:0]  ev_page;
  } xlate_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [2:0]  out_tuser;

  tlb_page_table_fifo_mmu #(.TLB_ENTRIES(TLB_N), .FRAME_COUNT(FRAMES)) dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

  always #5 clk = ~clk;

  // Shadow translation state
  logic        m_tlb_v  [TLB_N];
  page_t       m_tlb_pg [TLB_N];
  page_t       m_tlb_fr [TLB_N];
  logic        m_pg_v   [256];
  page_t       m_pg_fr  [256];
  page_t       m_owner  [FRAMES];
  int unsigned m_fifo;
  logic [15:0] m_lfsr;

  logic [15:0] addr_q [$];
  xlate_t      xlate_q [$];
  int          errors = 0;
  int          wd_cnt = 0;
  bit          stim_done = 1'b0;
  bit          quiet_in = 1'b0;
  bit          quiet_out = 1'b0;
  bit          hold_out = 1'b0;

  function automatic void model_reset();
    for (int i = 0; i < TLB_N; i++) m_tlb_v[i] = 1'b0;
    for (int i = 0; i < 256; i++) begin
      m_pg_v[i] = 1'b0;
      m_pg_fr[i] = '0;
    end
    for (int i = 0; i < FRAMES; i++) m_owner[i] = '0;
    m_fifo = 0;
    m_lfsr = LFSR_SEED;
  endfunction

  // Translate one address and update the shadow state
  function automatic xlate_t translate(logic [15:0] a);
    xlate_t r;
    page_t  pg, fr, own;
    int     slot;
    bit     found;
    pg = a[15:8];
    fr = '0;
    found = 1'b0;
    r = '0;
    for (int i = 0; i < TLB_N; i++) begin
      if (!found && m_tlb_v[i] && m_tlb_pg[i] == pg) begin
        fr = m_tlb_fr[i];
        found = 1'b1;
      end
    end
    if (found) begin
      r.hit = 1'b1;
    end else begin
      if (m_pg_v[pg]) begin
        fr = m_pg_fr[pg];
      end else begin
        r.fault = 1'b1;
        fr = page_t'(m_fifo);
        m_fifo = (m_fifo + 1 >= FRAMES) ? 0 : m_fifo + 1;
        own = m_owner[fr];
        m_owner[fr] = pg;
        if (m_pg_v[own] && m_pg_fr[own] == fr) begin
          r.evicted = 1'b1;
          r.ev_page = own;
          for (int i = 0; i < TLB_N; i++) begin
            if (m_tlb_v[i] && m_tlb_pg[i] == own) begin
              m_tlb_v[i] = 1'b0;
              break;
            end
          end
          m_pg_v[own] = 1'b0;
        end
        m_pg_fr[pg] = fr;
        m_pg_v[pg] = 1'b1;
      end
      slot = -1;
      for (int i = 0; i < TLB_N; i++) begin
        if (slot < 0 && !m_tlb_v[i]) slot = i;
      end
      if (slot < 0) begin
        slot = m_lfsr % TLB_N;
        m_lfsr = {m_lfsr[0] ^ m_lfsr[2] ^ m_lfsr[3] ^ m_lfsr[5], m_lfsr[15:1]};
      end
      m_tlb_pg[slot] = pg;
      m_tlb_fr[slot] = fr;
      m_tlb_v[slot] = 1'b1;
    end
    r.phys = {fr, a[7:0]};
    return r;
  endfunction

  // Drive input transfers from the pending queue
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (addr_q.size() > 0 && (quiet_in || $urandom_range(99) >= 14)) begin
          in_tdata  <= addr_q[0];
          in_tvalid <= 1'b1;
          xlate_q.push_back(translate(addr_q.pop_front()));
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Accept and check results
  always @(posedge clk) begin
    xlate_t e;
    if (rst_n) begin
      out_tready <= !hold_out && (quiet_out || $urandom_range(99) >= 14);
      if (out_tvalid && out_tready) begin
        if (xlate_q.size() == 0) begin
          $error("result with no translation pending");
          errors++;
        end else begin
          e = xlate_q.pop_front();
          if (out_tdata[15:0] !== e.phys) begin
            $error("physical_address exp %h got %h", e.phys, out_tdata[15:0]);
            errors++;
          end
          if (out_tuser[0] !== e.hit) begin
            $error("tlb_hit exp %b got %b", e.hit, out_tuser[0]);
            errors++;
          end
          if (out_tuser[1] !== e.fault) begin
            $error("page_fault exp %b got %b", e.fault, out_tuser[1]);
            errors++;
          end
          if (out_tuser[2] !== e.evicted) begin
            $error("evicted exp %b got %b", e.evicted, out_tuser[2]);
            errors++;
          end
          if (out_tdata[23:16] !== e.ev_page) begin
            $error("evicted_page exp %h got %h", e.ev_page, out_tdata[23:16]);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) wd_cnt <= 0;
    else wd_cnt <= wd_cnt + 1;
    if (wd_cnt >= WD_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Hold the receiver off for a long stretch while inputs keep being offered
  initial begin
    wait (rst_n);
    repeat (300) @(posedge clk);
    hold_out = 1'b1;
    repeat (200) @(posedge clk);
    hold_out = 1'b0;
  end

  function automatic logic [15:0] rand_addr(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return {8'($urandom_range(15)), 8'($urandom)};
      default: return {8'($urandom_range(40)), 8'($urandom)};
    endcase
  endfunction

  initial begin
    int mode;
    model_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: extremes, hit, resident miss, full TLB
    addr_q.push_back(16'h0000);
    addr_q.push_back(16'hFFFF);
    addr_q.push_back(16'h00FF);
    addr_q.push_back(16'hFF00);
    addr_q.push_back(16'h5AA5);
    addr_q.push_back(16'hA55A);
    for (int p = 1; p <= 18; p++) addr_q.push_back({8'(p), 8'(p * 7)});
    addr_q.push_back(16'h0042);
    // Pause until every result has come
    wait (addr_q.size() == 0 && xlate_q.size() == 0);
    // Walk over all frames so the ring wraps
    for (int p = 0; p < 300; p++) addr_q.push_back({8'(p * 37 + 11), 8'($urandom)});
    wait (addr_q.size() == 0);
    quiet_in = 1'b1;
    quiet_out = 1'b1;
    for (int k = 0; k < 100; k++) addr_q.push_back(rand_addr(2));
    wait (addr_q.size() == 0);
    quiet_in = 1'b0;
    quiet_out = 1'b0;
    for (int k = 0; k < 450; k++) begin
      mode = $urandom_range(2);
      addr_q.push_back(rand_addr(mode));
    end
    wait (addr_q.size() == 0 && xlate_q.size() == 0);
    repeat (40) @(posedge clk);
    if (errors == 0 && xlate_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
rtl/tlbpt_pkg.sv
rtl/tlbpt_vmod.sv
rtl/tlbpt_tlb.sv
rtl/tlbpt_tables.sv
rtl/tlb_page_table_fifo_mmu.sv
sim/tlb_page_table_fifo_mmu_tb.sv
